// ----- rtl/uer_pkg.sv -----
// Package: shared types, constants and codes for the ultrasonic echo ranger.
package uer_pkg;

    // Echo counter width and saturation value
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Trigger length register
    localparam int TRIG_W = 8;
    localparam logic [TRIG_W-1:0] TRIG_TICKS_RESET = 8'd20;

    // Result field widths
    localparam int DIST_W  = 11;
    localparam int DIGIT_W = 4;
    localparam logic [DIST_W-1:0]  DIST_MAX = 11'd2047;
    localparam logic [DIGIT_W-1:0] HUND_MAX = 4'd15;

    // distance = floor(count * 17 / 1000): count * 17 then a reciprocal multiply.
    // With RECIP = ceil(2^SHIFT / 1000) the error term stays below 2^10, so
    // SHIFT = PROD_W + 10 makes the quotient exact for every product value.
    localparam int PROD_W     = COUNT_BITS + 5;
    localparam int DIST_SHIFT = PROD_W + 10;
    localparam int RECIP_W    = PROD_W + 1;
    localparam int MQ_W       = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_DIST =
        RECIP_W'(((64'd1 << DIST_SHIFT) + 64'd999) / 64'd1000);

    // Decimal digits: d / 100 = (d * 5243) >> 19, r / 10 = (r * 205) >> 11
    localparam int HUND_RECIP_W = 13;
    localparam logic [HUND_RECIP_W-1:0] HUND_RECIP = 13'd5243;
    localparam int HUND_SHIFT = 19;
    localparam int HP_W       = DIST_W + HUND_RECIP_W;
    localparam logic [DIST_W-1:0] HUNDRED = 11'd100;
    localparam int REM_W      = 7;
    localparam int TENS_RECIP_W = 8;
    localparam logic [TENS_RECIP_W-1:0] TENS_RECIP = 8'd205;
    localparam int TENS_SHIFT = 11;
    localparam int TP_W       = REM_W + TENS_RECIP_W;
    localparam logic [REM_W-1:0] TEN = 7'd10;

    // Command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic CFG_IDX_TRIG = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRIG  = 2'd1,
        PH_WAIT  = 2'd2,
        PH_COUNT = 2'd3
    } t_phase;

    typedef struct packed {
        logic start_req;
        logic echo;
    } t_in_item;

    typedef struct packed {
        logic                trigger;
        logic                busy_res;
        logic                done_res;
        logic                overflow;
        logic [DIST_W-1:0]   distance_cm;
        logic [DIGIT_W-1:0]  hundreds_digit;
        logic [DIGIT_W-1:0]  tens_digit;
        logic [DIGIT_W-1:0]  ones_digit;
    } t_out_item;

    // Per-tick status computed by the front
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
        logic ovf;
    } t_flags;

    typedef struct packed {
        t_flags                flags;
        logic [COUNT_BITS-1:0] echo_count;
    } t_cmd;

endpackage

// ----- rtl/uer_front.sv -----
// Front: measurement state machine, one tick per accepted item.
module uer_front import uer_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_in_item          i_item,
    input  logic [TRIG_W-1:0] i_trigger_ticks,
    input  logic              i_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    t_phase                r_phase, n_phase;
    logic [TRIG_W-1:0]     r_trig_cnt, n_trig_cnt;
    logic [COUNT_BITS-1:0] r_echo_cnt, n_echo_cnt;
    logic                  r_ovf, n_ovf;
    logic                  trig;
    logic                  done;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_trig_cnt <= '0;
            r_echo_cnt <= '0;
            r_ovf      <= 1'b0;
        end else if (o_push) begin
            r_phase    <= n_phase;
            r_trig_cnt <= n_trig_cnt;
            r_echo_cnt <= n_echo_cnt;
            r_ovf      <= n_ovf;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_trig_cnt = r_trig_cnt;
        n_echo_cnt = r_echo_cnt;
        n_ovf      = r_ovf;
        trig       = 1'b0;
        done       = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_item.start_req) begin
                    n_phase    = PH_TRIG;
                    n_trig_cnt = TRIG_W'(1);
                    n_echo_cnt = '0;
                    n_ovf      = 1'b0;
                    trig       = 1'b1;
                end
            end
            PH_TRIG: begin
                if (r_trig_cnt >= i_trigger_ticks) begin
                    n_phase = PH_WAIT;
                end else begin
                    n_trig_cnt = r_trig_cnt + TRIG_W'(1);
                    trig       = 1'b1;
                end
            end
            PH_WAIT: begin
                if (i_item.echo) begin
                    n_phase    = PH_COUNT;
                    n_echo_cnt = COUNT_BITS'(1);
                end
            end
            PH_COUNT: begin
                if (i_item.echo) begin
                    // saturate: hold the count, flag the overflow
                    if (r_echo_cnt == COUNT_MAX) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_echo_cnt = r_echo_cnt + COUNT_BITS'(1);
                    end
                end else begin
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        o_cmd.flags.trig = trig;
        o_cmd.flags.busy = (n_phase != PH_IDLE);
        o_cmd.flags.done = done;
        o_cmd.flags.ovf  = n_ovf;
        o_cmd.echo_count = r_echo_cnt;
    end

    a_done_from_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.flags.done) |-> (r_phase == PH_COUNT))
        else $error("distance produced outside the counting phase");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_phase == PH_IDLE && i_item.start_req)
        |=> (r_phase == PH_TRIG && r_trig_cnt == TRIG_W'(1) && !r_ovf))
        else $error("start did not arm the trigger phase");

    a_ovf_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_echo_cnt == COUNT_MAX))
        else $error("overflow flag set below the saturated count");

endmodule

// ----- rtl/uer_fifo.sv -----
// Command queue between the front and the back.
module uer_fifo import uer_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_AW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (FIFO_AW + 1)'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + (FIFO_AW + 1)'(1)))
        else $error("queue count missed a push");

endmodule

// ----- rtl/uer_back.sv -----
// Back: distance and digit pipeline, last-result hold and output register.
module uer_back import uer_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic en;

    // stage A: count * 17
    logic              r_a_v;
    t_flags            r_a_flags;
    logic [PROD_W-1:0] r_a_prod;
    // stage B: reciprocal multiply
    logic              r_b_v;
    t_flags            r_b_flags;
    logic [MQ_W-1:0]   r_b_mq;
    // stage C: distance with saturation
    logic              r_c_v;
    t_flags            r_c_flags;
    logic [DIST_W-1:0] r_c_dist;
    // stage D: hundreds reciprocal product
    logic              r_d_v;
    t_flags            r_d_flags;
    logic [DIST_W-1:0] r_d_dist;
    logic [HP_W-1:0]   r_d_hprod;
    // stage E: hundreds digit and remainder
    logic               r_e_v;
    t_flags             r_e_flags;
    logic [DIST_W-1:0]  r_e_dist;
    logic [DIGIT_W-1:0] r_e_hund;
    logic [REM_W-1:0]   r_e_rem;
    // output and last result
    logic               r_out_v;
    t_out_item          r_out;
    logic [DIST_W-1:0]  r_last_dist;
    logic [DIGIT_W-1:0] r_last_hund;
    logic [DIGIT_W-1:0] r_last_tens;
    logic [DIGIT_W-1:0] r_last_ones;

    logic [31:0]        q32;
    logic [DIST_W-1:0]  n_dist;
    logic [DIST_W-1:0]  hq_full;
    logic [DIST_W-1:0]  rem_full;
    logic [TP_W-1:0]    tprod;
    logic [REM_W-1:0]   tens_full;
    logic [REM_W-1:0]   ones_full;

    // whole pipeline advances together when the output register is free
    assign en    = !r_out_v || i_ready;
    assign o_pop = en && i_cmd_valid;

    always_comb begin
        q32       = 32'(r_b_mq >> DIST_SHIFT);
        n_dist    = (q32 > 32'(DIST_MAX)) ? DIST_MAX : q32[DIST_W-1:0];
        hq_full   = DIST_W'(r_d_hprod >> HUND_SHIFT);
        rem_full  = r_d_dist - DIST_W'(hq_full * HUNDRED);
        tprod     = TP_W'(r_e_rem) * TP_W'(TENS_RECIP);
        tens_full = REM_W'(tprod >> TENS_SHIFT);
        ones_full = r_e_rem - REM_W'(tens_full * TEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_c_v       <= 1'b0;
            r_d_v       <= 1'b0;
            r_e_v       <= 1'b0;
            r_out_v     <= 1'b0;
            r_last_dist <= '0;
            r_last_hund <= '0;
            r_last_tens <= '0;
            r_last_ones <= '0;
        end else if (en) begin
            r_a_v   <= i_cmd_valid;
            r_b_v   <= r_a_v;
            r_c_v   <= r_b_v;
            r_d_v   <= r_c_v;
            r_e_v   <= r_d_v;
            r_out_v <= r_e_v;
            if (r_e_v && r_e_flags.done) begin
                r_last_dist <= r_e_dist;
                r_last_hund <= r_e_hund;
                r_last_tens <= tens_full[DIGIT_W-1:0];
                r_last_ones <= ones_full[DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_flags <= i_cmd.flags;
            r_a_prod  <= PROD_W'({i_cmd.echo_count, 4'b0000}) + PROD_W'(i_cmd.echo_count);
            r_b_flags <= r_a_flags;
            r_b_mq    <= MQ_W'(r_a_prod) * MQ_W'(RECIP_DIST);
            r_c_flags <= r_b_flags;
            r_c_dist  <= n_dist;
            r_d_flags <= r_c_flags;
            r_d_dist  <= r_c_dist;
            r_d_hprod <= HP_W'(r_c_dist) * HP_W'(HUND_RECIP);
            r_e_flags <= r_d_flags;
            r_e_dist  <= r_d_dist;
            r_e_hund  <= (hq_full > DIST_W'(HUND_MAX)) ? HUND_MAX : hq_full[DIGIT_W-1:0];
            r_e_rem   <= rem_full[REM_W-1:0];
            r_out.trigger  <= r_e_flags.trig;
            r_out.busy_res <= r_e_flags.busy;
            r_out.done_res <= r_e_flags.done;
            r_out.overflow <= r_e_flags.ovf;
            // new distance on a done tick, else hold the last one
            if (r_e_flags.done) begin
                r_out.distance_cm    <= r_e_dist;
                r_out.hundreds_digit <= r_e_hund;
                r_out.tens_digit     <= tens_full[DIGIT_W-1:0];
                r_out.ones_digit     <= ones_full[DIGIT_W-1:0];
            end else begin
                r_out.distance_cm    <= r_last_dist;
                r_out.hundreds_digit <= r_last_hund;
                r_out.tens_digit     <= r_last_tens;
                r_out.ones_digit     <= r_last_ones;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

    a_out_tracks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.distance_cm == r_last_dist))
        else $error("output distance differs from held distance");

    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.tens_digit <= DIGIT_W'(9) && r_out.ones_digit <= DIGIT_W'(9)))
        else $error("digit out of decimal range");

    a_digits_recompose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.distance_cm < DIST_W'(1600))
        |-> (DIST_W'(r_out.hundreds_digit) * HUNDRED
             + DIST_W'(r_out.tens_digit) * DIST_W'(10)
             + DIST_W'(r_out.ones_digit) == r_out.distance_cm))
        else $error("digits do not recompose the distance");

endmodule

// ----- rtl/ultrasonic_echo_ranger.sv -----
// Top level: ultrasonic pulse-width ranger with configuration port.
// A result item passes the command queue, back stages A to E and the output register.
// Throughput: one tick per cycle while the result channel does not stall; the front state
// machine steps on each accepted tick and the back pipeline takes a new item every cycle.
// Reset (synchronous, active low): idle phase, counts and overflow cleared, last
// distance zero, trigger length 20 ticks, command queue and pipeline emptied.
module ultrasonic_echo_ranger import uer_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // tick input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  t_in_item           i_item,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output t_out_item          o_item,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [TRIG_W-1:0] r_trig_ticks;
    logic              cfg_wr;
    logic              push;
    logic              full;
    t_cmd              front_cmd;
    logic              q_valid;
    t_cmd              q_cmd;
    logic              pop;

    // Configuration: one register, word index taken from paddr[2].
    // Writes land in the access phase; reads return the register zero-extended.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_TRIG);
    assign prdata = (paddr[2] == CFG_IDX_TRIG) ? PDATA_W'(r_trig_ticks) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_ticks <= TRIG_TICKS_RESET;
        end else if (cfg_wr) begin
            r_trig_ticks <= pwdata[TRIG_W-1:0];
        end
    end

    // Front: run the trigger/wait/count state machine on every accepted tick
    // and push that tick's status and echo count (done marks the falling edge).
    uer_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_item          (i_item),
        .i_trigger_ticks (r_trig_ticks),
        .i_full          (full),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // Queue: decouple the front from output backpressure.
    uer_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back: convert the count to centimetres and decimal digits, hold the
    // last distance between measurements, and drive the result register.
    uer_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the ultrasonic echo ranger: a tick-level predictor.
module tb;
    import uer_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Quiet cycles tolerated before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to hold after the last result item before the final verdict
    localparam int TAIL_CYCLES = 30;
    // Trigger length register sits at byte address 4 * index
    localparam logic [PADDR_W-1:0] TRIG_ADDR = PADDR_W'(4 * CFG_IDX_TRIG);
    // Print at most this many mismatch lines; keep counting past it
    localparam int MAX_REPORTS = 50;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    t_in_item           i_item;
    logic               o_valid;
    logic               i_ready;
    t_out_item          o_item;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ultrasonic_echo_ranger dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the ranger's phase, counters and
    // the trigger length register.
    // ------------------------------------------------------------------
    t_phase                rng_phase;
    logic [TRIG_W-1:0]     trig_cnt;
    logic [TRIG_W-1:0]     trig_len;
    logic [COUNT_BITS-1:0] echo_cnt;
    logic [DIST_W-1:0]     dist_cm;
    logic                  ovf_flag;

    // Readings predicted for accepted ticks, oldest first
    t_out_item pending_readings[$];

    int  err_count;
    int  ticks_sent;
    int  idle_cycles;
    // When set, neither side idles: produces stretches at full rate
    bit  quiet;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: advance the ranger by one tick and return the reading
    // that tick shows. Distance is floor(count * 17 / 1000), clipped to the
    // 11-bit field; the hundreds digit clips at 15.
    // ------------------------------------------------------------------
    function automatic t_out_item range_tick(t_in_item tick);
        t_out_item   rd;
        logic [31:0] dist_raw;
        logic [31:0] hund;
        rd = '0;
        case (rng_phase)
            PH_IDLE: begin
                // Start is honored only here; it counts as trigger tick one
                if (tick.start_req) begin
                    rng_phase  = PH_TRIG;
                    trig_cnt   = 8'd1;
                    echo_cnt   = '0;
                    ovf_flag   = 1'b0;
                    rd.trigger = 1'b1;
                end
            end
            PH_TRIG: begin
                // Echo is ignored for the whole trigger pulse
                if (trig_cnt >= trig_len) begin
                    rng_phase = PH_WAIT;
                end else begin
                    trig_cnt   = trig_cnt + 8'd1;
                    rd.trigger = 1'b1;
                end
            end
            PH_WAIT: begin
                // No timeout: wait for the rising echo indefinitely
                if (tick.echo) begin
                    rng_phase = PH_COUNT;
                    echo_cnt  = COUNT_BITS'(1);
                end
            end
            default: begin
                if (tick.echo) begin
                    if (echo_cnt >= COUNT_MAX)
                        ovf_flag = 1'b1;
                    else
                        echo_cnt = echo_cnt + 1'b1;
                end else begin
                    dist_raw   = (32'(echo_cnt) * 32'd17) / 32'd1000;
                    dist_cm    = (dist_raw > 32'(DIST_MAX)) ? DIST_MAX : dist_raw[DIST_W-1:0];
                    rd.done_res = 1'b1;
                    rng_phase  = PH_IDLE;
                end
            end
        endcase
        hund = 32'(dist_cm) / 32'd100;
        rd.busy_res       = (rng_phase != PH_IDLE);
        rd.overflow       = ovf_flag;
        rd.distance_cm    = dist_cm;
        rd.hundreds_digit = (hund > 32'(HUND_MAX)) ? HUND_MAX : hund[DIGIT_W-1:0];
        rd.tens_digit     = DIGIT_W'((32'(dist_cm) % 32'd100) / 32'd10);
        rd.ones_digit     = DIGIT_W'(32'(dist_cm) % 32'd10);
        return rd;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report(string msg);
        if (err_count < MAX_REPORTS)
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Random idle lengths: mostly short, a few long
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (quiet || $urandom_range(0, 99) < 65)
            return 0;
        return idle_len();
    endfunction

    // ------------------------------------------------------------------
    // Tick channel driver. Valid stays high after acceptance; the next
    // call either replaces the item at the following falling edge or drops
    // valid for a gap first, so valid is never touched twice in one step.
    // ------------------------------------------------------------------
    task automatic send_tick(t_in_item tick);
        int gap;
        gap = sender_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= tick;
        do @(posedge i_clk); while (!o_ready);
        pending_readings.push_back(range_tick(tick));
        ticks_sent++;
    endtask

    task automatic send_bits(bit start, bit echo);
        t_in_item tick;
        tick.start_req = start;
        tick.echo      = echo;
        send_tick(tick);
    endtask

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Drop valid and hold until every predicted reading has come back
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port: setup cycle, access cycle, then release
    // ------------------------------------------------------------------
    task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_trigger_len(int want);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b0, TRIG_ADDR, '0, rd);
        check_field("trigger_ticks readback", int'(rd), want);
    endtask

    // Write only with nothing in flight and the ranger back in idle
    task automatic write_trigger_len(int len);
        logic [PDATA_W-1:0] rd;
        wait_results_drained();
        apb_access(1'b1, TRIG_ADDR, PDATA_W'(len), rd);
        trig_len = TRIG_W'(len);
        read_trigger_len(len);
    endtask

    // ------------------------------------------------------------------
    // One well-formed measurement from idle: start, trigger pulse with
    // random junk on both bits, quiet wait, echo pulse, falling edge.
    // ------------------------------------------------------------------
    task automatic run_measurement(int wait_ticks, int echo_ticks);
        send_bits(1'b1, coin());
        while (rng_phase == PH_TRIG) send_bits(coin(), coin());
        repeat (wait_ticks) send_bits(coin(), 1'b0);
        repeat (echo_ticks) send_bits(coin(), 1'b1);
        send_bits(coin(), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset value of the trigger length, echo ignored while idle, and one
    // measurement with the default 20-tick trigger.
    task automatic test_reset_state();
        read_trigger_len(int'(TRIG_TICKS_RESET));
        send_bits(1'b0, 1'b1);
        send_bits(1'b0, 1'b0);
        send_bits(1'b0, 1'b1);
        run_measurement(2, 1);
    endtask

    // Short hand-built sequences for the corner cases of the state machine
    task automatic test_directed_cases();
        write_trigger_len(1);
        // Start with echo high; the trigger's closing tick sees start and
        // echo both high and must ignore them
        send_bits(1'b1, 1'b1);
        send_bits(1'b1, 1'b1);
        send_bits(1'b0, 1'b0);
        // Single-tick echo gives distance zero; start during the count is
        // ignored, start right after done is taken
        send_bits(1'b1, 1'b1);
        send_bits(1'b1, 1'b0);
        send_bits(1'b1, 1'b0);
        send_bits(1'b0, 1'b1);
        send_bits(1'b0, 1'b1);
        send_bits(1'b0, 1'b1);
        send_bits(1'b0, 1'b0);
        // Zero-length trigger acts like one tick
        write_trigger_len(0);
        send_bits(1'b1, 1'b0);
        send_bits(1'b0, 1'b1);
        send_bits(1'b0, 1'b1);
        send_bits(1'b1, 1'b0);
        send_bits(1'b0, 1'b0);
        // Longest trigger pulse
        write_trigger_len(255);
        run_measurement(0, 1);
    endtask

    // Echo lengths that land on and just below the first distance steps
    task automatic test_digit_boundaries();
        int dists[2] = '{1, 2};
        int cnt;
        write_trigger_len(2);
        quiet = 1'b1;
        foreach (dists[i]) begin
            // smallest count whose distance reaches dists[i]
            cnt = (dists[i] * 1000 + 16) / 17;
            if (dists[i] <= 110)
                run_measurement(1, cnt - 1);
            run_measurement(1, cnt);
        end
        quiet = 1'b0;
    endtask

    // Random measurements over several trigger lengths, with idle noise,
    // glitch echoes, echoes around the tens roll-over and one full pause
    task automatic test_random_measurements();
        int lens[5];
        int before_meas;
        int measured;
        int echo_ticks;
        int wait_ticks;
        bit paused;
        lens[0] = 3;
        lens[1] = 255;
        lens[2] = $urandom_range(1, 40);
        lens[3] = 1;
        lens[4] = $urandom_range(2, 254);
        paused  = 1'b0;
        foreach (lens[p]) begin
            write_trigger_len(lens[p]);
            measured = 0;
            while (measured < 120) begin
                quiet = ($urandom_range(0, 3) == 0);
                // Idle noise: start low, echo random; ignored by the ranger
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 5)) send_bits(1'b0, coin());
                wait_ticks = $urandom_range(0, 10);
                case ($urandom_range(0, 19))
                    0, 1:       echo_ticks = $urandom_range(1, 2);
                    2, 3:       echo_ticks = $urandom_range(575, 600);
                    4, 5, 6, 7: echo_ticks = $urandom_range(121, 250);
                    default:    echo_ticks = $urandom_range(1, 120);
                endcase
                before_meas = ticks_sent;
                run_measurement(wait_ticks, echo_ticks);
                measured += ticks_sent - before_meas;
                // Hold the sender once until every reading is back
                if (!paused && measured > 150) begin
                    wait_results_drained();
                    paused = 1'b1;
                end
            end
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result receiver: ready with random stalls, short and long
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted reading with the oldest
    // prediction, field by field
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_readings.size() == 0) begin
                report("result item with no tick outstanding");
            end else begin
                want = pending_readings.pop_front();
                check_field("trigger", int'(o_item.trigger), int'(want.trigger));
                check_field("busy_res", int'(o_item.busy_res), int'(want.busy_res));
                check_field("done_res", int'(o_item.done_res), int'(want.done_res));
                check_field("overflow", int'(o_item.overflow), int'(want.overflow));
                check_field("distance_cm", int'(o_item.distance_cm),
                            int'(want.distance_cm));
                check_field("hundreds_digit", int'(o_item.hundreds_digit),
                            int'(want.hundreds_digit));
                check_field("tens_digit", int'(o_item.tens_digit),
                            int'(want.tens_digit));
                check_field("ones_digit", int'(o_item.ones_digit),
                            int'(want.ones_digit));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no handshake of any kind happens for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired with %0d readings outstanding",
                     pending_readings.size());
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Drive every input known from time zero
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        quiet       = 1'b0;
        err_count   = 0;
        ticks_sent  = 0;

        // Predictor reset state
        rng_phase = PH_IDLE;
        trig_cnt  = '0;
        trig_len  = TRIG_TICKS_RESET;
        echo_cnt  = '0;
        dist_cm   = '0;
        ovf_flag  = 1'b0;

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_directed_cases();
        test_digit_boundaries();
        test_random_measurements();

        // Drain, then give the pipeline time to show any stray result
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_readings.size() != 0)
            report($sformatf("%0d readings never arrived", pending_readings.size()));

        if (err_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
